FILE: design/sai_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-add integer ALU package
// Shared constants, command codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package sai_pkg;

  // Default operand and result width.
  localparam int DATA_WIDTH = 32;

  // Command codes carried on the command channel.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // Capture the accepted operands and command.
    logic setup;     // Prepare the operation or finish one that needs no iterations.
    logic step;      // One shift-add or shift-subtract iteration.
    logic fix;       // Form the final result after the iterations.
    logic load_out;  // Move the result into the output register.
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic iterate;   // The captured command needs the bit-serial loop.
    logic last;      // The current iteration is the final one.
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: design/sai_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Command channel interface
// Valid/ready channel carrying one ALU command and its two operands.
// ----------------------------------------------------------------------------
interface sai_cmd_if #(
  parameter int DATA_WIDTH = sai_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

FILE: design/sai_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one ALU result and the divide-by-zero flag.
// ----------------------------------------------------------------------------
interface sai_res_if #(
  parameter int DATA_WIDTH = sai_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result;
  logic                         divide_by_zero;

  modport source (output valid, result, divide_by_zero, input ready);
  modport sink (input valid, result, divide_by_zero, output ready);
endinterface
`default_nettype wire

FILE: design/sai_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-add integer ALU controller
// One-hot state machine that sequences the datapath and owns the output
// valid flag.
// ----------------------------------------------------------------------------
module sai_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sai_pkg::dp_ctrl_t     ctl,
  input  wire sai_pkg::dp_stat_t stat
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_ITER = 5'b00100,
    ST_FIX  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.load_in  = in_valid && in_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl.setup  = 1'b1;
        state_next = stat.iterate ? ST_ITER : ST_DONE;
      end
      ST_ITER: begin
        ctl.step = 1'b1;
        if (stat.last) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        ctl.fix    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag: set when a result is loaded, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: design/sai_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-add integer ALU datapath
// Operand registers, a shared shift-add / shift-subtract unit, the iteration
// counter and the output payload register.
// ----------------------------------------------------------------------------
module sai_dp #(
  parameter int DATA_WIDTH = sai_pkg::DATA_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sai_pkg::dp_ctrl_t     ctl,
  output sai_pkg::dp_stat_t          stat,
  input  wire logic [1:0]            command,
  input  wire logic [DATA_WIDTH-1:0] operand_a,
  input  wire logic [DATA_WIDTH-1:0] operand_b,
  output logic [DATA_WIDTH-1:0]      result,
  output logic                       divide_by_zero
);

  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  sai_pkg::op_t          op;
  logic [DATA_WIDTH-1:0] opa;   // Multiplicand, later dividend/quotient.
  logic [DATA_WIDTH-1:0] opb;   // Multiplier, later divisor magnitude.
  logic [DATA_WIDTH-1:0] acc;   // Product or partial remainder.
  logic [DATA_WIDTH-1:0] res;
  logic [CNT_W-1:0]      cnt;
  logic                  neg;
  logic                  dz;

  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic [DATA_WIDTH-1:0] rem_sh;
  logic                  ge;
  logic                  b_zero;

  // Magnitudes for division; the minimum value maps onto itself as unsigned.
  assign mag_a  = opa[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - opa) : opa;
  assign mag_b  = opb[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - opb) : opb;
  assign b_zero = (opb == {DATA_WIDTH{1'b0}});

  // Restoring divide step: bring in the next dividend bit and try a subtract.
  assign rem_sh = {acc[DATA_WIDTH-2:0], opa[DATA_WIDTH-1]};
  assign ge     = (rem_sh >= opb);

  assign stat.iterate = (op == sai_pkg::OP_MUL) || ((op == sai_pkg::OP_DIV) && !b_zero);
  assign stat.last    = (cnt == CNT_LAST);

  // Operand capture, set-up, iterations and final result.
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      op  <= sai_pkg::op_t'(command);
      opa <= operand_a;
      opb <= operand_b;
    end
    if (ctl.setup) begin
      cnt <= '0;
      neg <= opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
      dz  <= (op == sai_pkg::OP_DIV) && b_zero;
      acc <= '0;
      case (op)
        sai_pkg::OP_ADD: res <= opa + opb;
        sai_pkg::OP_SUB: res <= opa - opb;
        sai_pkg::OP_DIV: begin
          res <= '0;
          opa <= mag_a;
          opb <= mag_b;
        end
        default: res <= '0;
      endcase
    end
    if (ctl.step) begin
      cnt <= cnt + 1'b1;
      if (op == sai_pkg::OP_MUL) begin
        acc <= acc + (opb[0] ? opa : {DATA_WIDTH{1'b0}});
        opa <= {opa[DATA_WIDTH-2:0], 1'b0};
        opb <= {1'b0, opb[DATA_WIDTH-1:1]};
      end else begin
        acc <= ge ? (rem_sh - opb) : rem_sh;
        opa <= {opa[DATA_WIDTH-2:0], ge};
      end
    end
    if (ctl.fix) begin
      if (op == sai_pkg::OP_MUL) begin
        res <= acc;
      end else begin
        res <= neg ? ({DATA_WIDTH{1'b0}} - opa) : opa;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (rst) begin
      divide_by_zero <= 1'b0;
    end else if (ctl.load_out) begin
      divide_by_zero <= dz;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      result <= res;
    end
  end

endmodule
`default_nettype wire

FILE: design/shift_add_integer_alu_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-add integer ALU top level
// Add, subtract, multiply and signed divide on two's complement operands.
// ----------------------------------------------------------------------------
// One command is worked on at a time. Add and subtract, and a divide by zero,
// are finished in the set-up state and then load their result into the output
// register, after which the controller returns to idle for the next command.
// Multiply and divide run a one-bit-per-cycle shift-add or restoring
// shift-subtract loop in the datapath: the set-up state, DATA_WIDTH iterations
// and a final state that takes the product or applies the quotient sign, after
// which the result is loaded and the next command can be accepted. The result
// sits in an output register, so a new command is accepted while the previous
// result is still waiting to be taken; that new command then holds its
// finished result, and the input, until the output register is drained.
// Division truncates toward zero; the minimum value divided by minus one wraps
// to the minimum value; a zero divisor returns 0 with divide_by_zero set.
module shift_add_integer_alu_top #(
  parameter int DATA_WIDTH = sai_pkg::DATA_WIDTH
) (
  input wire logic  clk,
  input wire logic  rst,
  sai_cmd_if.sink   cmd_ch,
  sai_res_if.source res_ch
);

  sai_pkg::dp_ctrl_t     ctl;
  sai_pkg::dp_stat_t     stat;
  logic [DATA_WIDTH-1:0] result;

  // Sequencing.
  sai_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_ch.valid),
    .in_ready (cmd_ch.ready),
    .out_valid(res_ch.valid),
    .out_ready(res_ch.ready),
    .ctl      (ctl),
    .stat     (stat)
  );

  // Arithmetic.
  sai_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .command       (cmd_ch.command),
    .operand_a     (cmd_ch.operand_a),
    .operand_b     (cmd_ch.operand_b),
    .result        (result),
    .divide_by_zero(res_ch.divide_by_zero)
  );

  assign res_ch.result = result;

endmodule
`default_nettype wire

FILE: design/sai_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-add integer ALU checker
// Port-level assertions on the command and result channels, bound to the top.
// ----------------------------------------------------------------------------
module sai_checker #(
  parameter int DATA_WIDTH = sai_pkg::DATA_WIDTH
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  cmd_valid,
  input wire logic                  cmd_ready,
  input wire logic                  res_valid,
  input wire logic                  res_ready,
  input wire logic [DATA_WIDTH-1:0] result,
  input wire logic                  divide_by_zero
);

  // A stalled result transaction keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(result) && $stable(divide_by_zero))
    else $error("result changed while stalled");

  // Only one command is in flight: none is taken right after acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while another is in flight");

  // A zero divisor always returns zero.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && divide_by_zero |-> result == '0)
    else $error("divide by zero with nonzero result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind shift_add_integer_alu_top sai_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_sai_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd_ch.valid),
  .cmd_ready     (cmd_ch.ready),
  .res_valid     (res_ch.valid),
  .res_ready     (res_ch.ready),
  .result        (res_ch.result),
  .divide_by_zero(res_ch.divide_by_zero)
);
`default_nettype wire
